[sv/tma_pkg.sv]
// ---------------------------------------------------------------------------
// tma_pkg: shared types and constants for the triangle mesh adjacency block
// Sizes of the stores, operation and status codes, controller states and
// the candidate match flags.
// ---------------------------------------------------------------------------
package tma_pkg;

  // store sizes
  localparam int MAX_TRIANGLES = 4096;
  localparam int MAX_VERTICES  = 4096;
  localparam int MAX_INCIDENT  = 16;

  localparam int TRI_W    = $clog2(MAX_TRIANGLES);        // triangle index
  localparam int VTX_W    = $clog2(MAX_VERTICES);         // vertex index
  localparam int INC_W    = $clog2(MAX_INCIDENT);         // slot in a list
  localparam int CNT_W    = $clog2(MAX_INCIDENT + 1);     // list fill count
  localparam int LOADED_W = $clog2(MAX_TRIANGLES + 1);    // loaded triangles
  localparam int LST_AW   = VTX_W + INC_W;                // incidence address
  localparam int TRI_DW   = 3 * VTX_W;                    // packed corners
  localparam int NB_W     = 13;                           // signed neighbor

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NONMANIFOLD = 2'd1;
  localparam logic [1:0] ST_NOT_LOADED  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW    = 2'd3;

  localparam logic [NB_W-1:0] NB_NONE = {NB_W{1'b1}};

  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [TRI_W-1:0] tri_idx_t;

  typedef enum logic [3:0] {
    S_CLR,      // zero the incidence counts
    S_IDLE,
    S_LD_RD,    // read count of one corner
    S_LD_WR,    // append to that corner's list
    S_Q_SELF,   // queried triangle's corners arrive
    S_Q_CNT,    // read count of one corner
    S_Q_CNTW,   // count arrives
    S_Q_SCAN,   // stream candidates through list and triangle reads
    S_Q_DONE    // publish result
  } state_t;

  // verdict on one candidate
  typedef struct packed {
    logic adj;  // exactly two equal vertex pairs
    logic dup;  // already among the neighbors found
  } match_t;

endpackage

[sv/tma_ram.sv]
// ---------------------------------------------------------------------------
// tma_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tma_match.sv]
// ---------------------------------------------------------------------------
// tma_match: candidate test for the adjacency scan
// Counts equal vertex pairs between the queried triangle and a candidate
// and checks the candidate against the neighbors already found.
// ---------------------------------------------------------------------------
module tma_match import tma_pkg::*; (
  input  vtx_t     self_v  [3],
  input  vtx_t     cand_v  [3],
  input  tri_idx_t cand,
  input  tri_idx_t nb      [3],
  input  logic [1:0] n,
  output match_t   verdict
);

  logic [3:0] eq_cnt;
  logic       dup;

  // nine pairwise comparisons
  always_comb begin
    eq_cnt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        eq_cnt = eq_cnt + {3'd0, self_v[i] == cand_v[j]};
      end
    end
  end

  // duplicate check over the filled slots
  always_comb begin
    dup = 1'b0;
    for (int m = 0; m < 3; m++) begin
      if (2'(m) < n && nb[m] == cand) begin
        dup = 1'b1;
      end
    end
  end

  assign verdict.adj = (eq_cnt == 4'd2);
  assign verdict.dup = dup;

endmodule

[sv/triangle_mesh_adjacency.sv]
// ---------------------------------------------------------------------------
// triangle_mesh_adjacency: edge adjacency of a triangle mesh
// Stores triangles and per-vertex incidence lists in block RAM and answers
// adjacency queries by scanning the lists of the queried triangle's corners.
// ---------------------------------------------------------------------------
// Timing: after reset and after every clear item the block zeroes its 4096
// incidence counts, one per cycle, and holds busy while it does so.
// A load makes three read-modify-write passes on the count RAM. A valid
// query scans the lists of its three corners; candidates stream one per
// cycle through the incidence-list read and the triangle read. A query's
// result appears on the out_ ports for exactly one cycle with out_valid
// high, in the cycle in which busy drops (the cycle after acceptance for an
// index not loaded); the receiver cannot stall it, so it must take every
// result when it is shown. Loads and clears give no result. A load past
// the triangle or list capacity sets a sticky overflow that makes later
// queries of loaded triangles report status 3 until a clear.
// ---------------------------------------------------------------------------
module triangle_mesh_adjacency import tma_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_operation,
  input  logic [11:0]      in_vertex_a,
  input  logic [11:0]      in_vertex_b,
  input  logic [11:0]      in_vertex_c,
  input  logic [11:0]      in_query_index,
  output logic             out_valid,
  output logic [11:0]      out_triangle_index,
  output logic signed [12:0] out_neighbor_first,
  output logic signed [12:0] out_neighbor_second,
  output logic signed [12:0] out_neighbor_third,
  output logic [1:0]       out_neighbor_count,
  output logic [1:0]       out_status
);

  state_t state_r, state_nxt;

  logic                accept;
  logic [LOADED_W-1:0] loaded_r;
  logic                ovf_r;
  logic [VTX_W-1:0]    clr_addr_r;
  vtx_t                v_r [3];
  logic [1:0]          k_r;
  tri_idx_t            q_r;
  vtx_t                self_r [3];
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    j_r;
  logic                s1_vld_r, s2_vld_r;
  tri_idx_t            cand_r;
  tri_idx_t            nb_r [3];
  logic [1:0]          n_r;
  logic                nonman_r;

  // memory ports
  logic              tri_we;
  tri_idx_t          tri_waddr, tri_raddr;
  logic [TRI_DW-1:0] tri_wdata, tri_rdata;
  logic              cnt_we;
  vtx_t              cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              lst_we;
  logic [LST_AW-1:0] lst_waddr, lst_raddr;
  tri_idx_t          lst_wdata, lst_rdata;

  logic              full;
  logic              scan_issue, scan_end;
  vtx_t              cand_v [3];
  match_t            verdict;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (loaded_r >= LOADED_W'(MAX_TRIANGLES));
  assign scan_issue = (j_r < cnt_r);
  assign scan_end   = !scan_issue && !s1_vld_r && !s2_vld_r;

  assign cand_v[0] = tri_rdata[3*VTX_W-1:2*VTX_W];
  assign cand_v[1] = tri_rdata[2*VTX_W-1:VTX_W];
  assign cand_v[2] = tri_rdata[VTX_W-1:0];

  // stores
  tma_ram #(.WIDTH(TRI_DW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
    .clk, .we(tri_we), .waddr(tri_waddr), .wdata(tri_wdata),
    .raddr(tri_raddr), .rdata(tri_rdata)
  );

  tma_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  tma_ram #(.WIDTH(TRI_W), .DEPTH(MAX_VERTICES * MAX_INCIDENT)) u_lst_ram (
    .clk, .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata(lst_rdata)
  );

  tma_match u_match (
    .self_v(self_r), .cand_v(cand_v), .cand(cand_r),
    .nb(nb_r), .n(n_r), .verdict(verdict)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_addr_r == VTX_W'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_LOAD:  if (!full) state_nxt = S_LD_RD;
            OP_QUERY: if ({1'b0, in_query_index} < loaded_r) state_nxt = S_Q_SELF;
            OP_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD:  state_nxt = S_LD_WR;
      S_LD_WR:  state_nxt = (k_r == 2'd2) ? S_IDLE : S_LD_RD;
      S_Q_SELF: state_nxt = S_Q_CNT;
      S_Q_CNT:  state_nxt = S_Q_CNTW;
      S_Q_CNTW: state_nxt = S_Q_SCAN;
      S_Q_SCAN: begin
        if (scan_end) state_nxt = (k_r == 2'd2) ? S_Q_DONE : S_Q_CNT;
      end
      S_Q_DONE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    tri_we    = 1'b0;
    tri_waddr = loaded_r[TRI_W-1:0];
    tri_wdata = {in_vertex_a, in_vertex_b, in_vertex_c};
    tri_raddr = (state_r == S_IDLE) ? in_query_index : lst_rdata;
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr_r;
    cnt_wdata = '0;
    cnt_raddr = self_r[k_r];
    lst_we    = 1'b0;
    lst_waddr = {v_r[k_r], cnt_rdata[INC_W-1:0]};
    lst_wdata = loaded_r[TRI_W-1:0];
    lst_raddr = {self_r[k_r], j_r[INC_W-1:0]};
    case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        tri_we = accept && (in_operation == OP_LOAD) && !full;
      end
      S_LD_RD: begin
        cnt_raddr = v_r[k_r];
      end
      S_LD_WR: begin
        if (cnt_rdata < CNT_W'(MAX_INCIDENT)) begin
          lst_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_waddr = v_r[k_r];
          cnt_wdata = cnt_rdata + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      loaded_r   <= '0;
      ovf_r      <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      s1_vld_r  <= (state_r == S_Q_SCAN) && scan_issue;
      s2_vld_r  <= s1_vld_r;
      case (state_r)
        S_CLR: clr_addr_r <= clr_addr_r + VTX_W'(1);
        S_IDLE: begin
          if (accept) begin
            case (in_operation)
              OP_LOAD: if (full) ovf_r <= 1'b1;
              OP_QUERY: begin
                if ({1'b0, in_query_index} >= loaded_r) out_valid <= 1'b1;
              end
              OP_CLEAR: begin
                clr_addr_r <= '0;
                loaded_r   <= '0;
                ovf_r      <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LD_WR: begin
          if (cnt_rdata >= CNT_W'(MAX_INCIDENT)) ovf_r <= 1'b1;
          if (k_r == 2'd2) loaded_r <= loaded_r + LOADED_W'(1);
        end
        S_Q_DONE: out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        v_r[0]   <= in_vertex_a;
        v_r[1]   <= in_vertex_b;
        v_r[2]   <= in_vertex_c;
        q_r      <= in_query_index;
        k_r      <= 2'd0;
        n_r      <= 2'd0;
        nonman_r <= 1'b0;
        if (accept && in_operation == OP_QUERY) begin
          out_triangle_index  <= in_query_index;
          out_neighbor_first  <= NB_NONE;
          out_neighbor_second <= NB_NONE;
          out_neighbor_third  <= NB_NONE;
          out_neighbor_count  <= 2'd0;
          out_status          <= ST_NOT_LOADED;
        end
      end
      S_LD_WR: k_r <= k_r + 2'd1;
      S_Q_SELF: begin
        self_r[0] <= tri_rdata[3*VTX_W-1:2*VTX_W];
        self_r[1] <= tri_rdata[2*VTX_W-1:VTX_W];
        self_r[2] <= tri_rdata[VTX_W-1:0];
      end
      S_Q_CNTW: begin
        cnt_r <= cnt_rdata;
        j_r   <= '0;
      end
      S_Q_SCAN: begin
        if (scan_issue) j_r <= j_r + CNT_W'(1);
        if (s1_vld_r) cand_r <= lst_rdata;
        // candidate verdict
        if (s2_vld_r && verdict.adj && !verdict.dup) begin
          if (n_r != 2'd3) begin
            nb_r[n_r] <= cand_r;
            n_r       <= n_r + 2'd1;
          end else begin
            nonman_r <= 1'b1;
          end
        end
        if (scan_end) k_r <= k_r + 2'd1;
      end
      S_Q_DONE: begin
        out_triangle_index  <= q_r;
        out_neighbor_first  <= (n_r > 2'd0) ? {1'b0, nb_r[0]} : NB_NONE;
        out_neighbor_second <= (n_r > 2'd1) ? {1'b0, nb_r[1]} : NB_NONE;
        out_neighbor_third  <= (n_r > 2'd2) ? {1'b0, nb_r[2]} : NB_NONE;
        out_neighbor_count  <= n_r;
        out_status          <= ovf_r ? ST_OVERFLOW : (nonman_r ? ST_NONMANIFOLD : ST_OK);
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/tb_triangle_mesh_adjacency.sv]
// ---------------------------------------------------------------------------
// tb_triangle_mesh_adjacency: self-checking bench for the mesh adjacency block
// Drives load, query and clear items through the start/busy handshake. A
// scoreboard keeps its own copy of the mesh, predicts every query result
// and compares each strobed result field by field, oldest first.
// ---------------------------------------------------------------------------
module tb_triangle_mesh_adjacency;
  import tma_pkg::*;

  // operation code the block ignores
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // expected query result
  typedef struct {
    logic [11:0]      tri_idx;
    logic [NB_W-1:0]  nb [3];
    logic [1:0]       count;
    logic [1:0]       status;
  } adj_result_t;

  // mesh copy and queue of pending query answers
  class mesh_scoreboard;
    logic [11:0] corners [MAX_TRIANGLES][3];
    int          fill [MAX_VERTICES];
    logic [11:0] lists [MAX_VERTICES][MAX_INCIDENT];
    int          n_loaded;
    bit          overflow;
    adj_result_t pending [$];
    int          errors;

    function void wipe();
      foreach (fill[i]) fill[i] = 0;
      n_loaded = 0;
      overflow = 0;
    endfunction

    function int shared_pairs(int p, int q);
      int n;
      n = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (corners[p][i] == corners[q][j]) n++;
      return n;
    endfunction

    // note one accepted input item
    function void note_item(logic [1:0] op, logic [11:0] va, logic [11:0] vb,
                            logic [11:0] vc, logic [11:0] qi);
      adj_result_t r;
      logic [11:0] v [3];
      int t, n, cand;
      bit dup, nonman;
      v[0] = va; v[1] = vb; v[2] = vc;
      case (op)
        OP_LOAD: begin
          if (n_loaded >= MAX_TRIANGLES) begin
            overflow = 1;
          end else begin
            t = n_loaded;
            for (int k = 0; k < 3; k++) begin
              corners[t][k] = v[k];
              if (fill[v[k]] >= MAX_INCIDENT) overflow = 1;
              else begin
                lists[v[k]][fill[v[k]]] = t[11:0];
                fill[v[k]]++;
              end
            end
            n_loaded = t + 1;
          end
        end
        OP_CLEAR: wipe();
        OP_QUERY: begin
          r.tri_idx = qi;
          n = 0;
          nonman = 0;
          r.status = ST_OK;
          if (qi >= n_loaded) r.status = ST_NOT_LOADED;
          else begin
            for (int k = 0; k < 3; k++)
              for (int j = 0; j < fill[corners[qi][k]]; j++) begin
                cand = lists[corners[qi][k]][j];
                if (shared_pairs(qi, cand) != 2) continue;
                dup = 0;
                for (int m = 0; m < n; m++) if (r.nb[m] == cand) dup = 1;
                if (dup) continue;
                if (n < 3) r.nb[n++] = cand[NB_W-1:0];
                else nonman = 1;
              end
            if (overflow) r.status = ST_OVERFLOW;
            else if (nonman) r.status = ST_NONMANIFOLD;
          end
          for (int k = n; k < 3; k++) r.nb[k] = NB_NONE;
          r.count = n[1:0];
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    // compare one strobed result with the oldest expectation
    function void check_result(logic [11:0] ti, logic [NB_W-1:0] n0,
                               logic [NB_W-1:0] n1, logic [NB_W-1:0] n2,
                               logic [1:0] cnt, logic [1:0] st);
      adj_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result for triangle %0d", ti);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ti !== e.tri_idx) begin
        $error("triangle_index exp %0d got %0d", e.tri_idx, ti); errors++;
      end
      if (n0 !== e.nb[0]) begin
        $error("neighbor_first exp %0d got %0d", $signed(e.nb[0]), $signed(n0)); errors++;
      end
      if (n1 !== e.nb[1]) begin
        $error("neighbor_second exp %0d got %0d", $signed(e.nb[1]), $signed(n1)); errors++;
      end
      if (n2 !== e.nb[2]) begin
        $error("neighbor_third exp %0d got %0d", $signed(e.nb[2]), $signed(n2)); errors++;
      end
      if (cnt !== e.count) begin
        $error("neighbor_count exp %0d got %0d", e.count, cnt); errors++;
      end
      if (st !== e.status) begin
        $error("status exp %0d got %0d", e.status, st); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_operation = OP_CLEAR;
  logic [11:0] in_vertex_a = '0, in_vertex_b = '0, in_vertex_c = '0;
  logic [11:0] in_query_index = '0;
  logic        out_valid;
  logic [11:0] out_triangle_index;
  logic signed [12:0] out_neighbor_first, out_neighbor_second, out_neighbor_third;
  logic [1:0]  out_neighbor_count, out_status;

  mesh_scoreboard mesh_sb = new();
  int idle_pct;
  int stall_cycles;

  triangle_mesh_adjacency uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // accept items and results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        mesh_sb.note_item(in_operation, in_vertex_a, in_vertex_b, in_vertex_c,
                          in_query_index);
      if (out_valid)
        mesh_sb.check_result(out_triangle_index, out_neighbor_first,
                             out_neighbor_second, out_neighbor_third,
                             out_neighbor_count, out_status);
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end else begin
      stall_cycles <= 0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // issue one item; start stays high across back-to-back items
  task automatic send_item(logic [1:0] op, logic [11:0] va, logic [11:0] vb,
                           logic [11:0] vc, logic [11:0] qi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_vertex_a <= va;
    in_vertex_b <= vb;
    in_vertex_c <= vc;
    in_query_index <= qi;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (busy || mesh_sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic load_tri(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    send_item(OP_LOAD, a, b, c, 12'($urandom));
  endtask

  task automatic query_tri(logic [11:0] q);
    send_item(OP_QUERY, 12'($urandom), 12'($urandom), 12'($urandom), q);
  endtask

  // random phase: small vertex pool so triangles share edges
  task automatic random_phase(int items);
    int pool, r;
    logic [11:0] base;
    pool = $urandom_range(3, 24);
    base = 12'($urandom_range(0, 4095 - pool));
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        load_tri(base + 12'($urandom_range(pool)), base + 12'($urandom_range(pool)),
                 base + 12'($urandom_range(pool)));
      end else if (r < 93) begin
        if ($urandom_range(9) == 0) query_tri(12'($urandom));
        else query_tri(12'($urandom_range(mesh_sb.n_loaded + 1)));
      end else if (r < 96) begin
        send_item(OP_UNKNOWN, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom));
      end else begin
        send_item(OP_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom));
        pool = $urandom_range(3, 24);
        base = 12'($urandom_range(0, 4095 - pool));
      end
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: fan of triangles around vertex 0, extremes, nonmanifold edge
    load_tri(12'd0, 12'd1, 12'd2);
    load_tri(12'd0, 12'd2, 12'd3);
    load_tri(12'd0, 12'd3, 12'd1);
    load_tri(12'd1, 12'd2, 12'd4095);
    load_tri(12'd0, 12'd1, 12'd5);
    load_tri(12'd4095, 12'd4095, 12'd4095);
    load_tri(12'd4095, 12'd2048, 12'd1);
    query_tri(12'd0);
    query_tri(12'd1);
    query_tri(12'd5);
    query_tri(12'd7);
    query_tri(12'd4095);
    send_item(OP_UNKNOWN, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    drain();
    // incidence list overflow on vertex 4095
    for (int i = 0; i < 17; i++) load_tri(12'd4095, 12'd4094, 12'(i));
    query_tri(12'd0);
    query_tri(12'd8);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    query_tri(12'd0);
    drain();

    idle_pct = 14;
    random_phase(320);
    drain();
    idle_pct = 84;
    random_phase(300);
    drain();
    idle_pct = 0;
    random_phase(330);

    drain();
    repeat (80) @(negedge clk);
    if (mesh_sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
